// ===== rtl/triangle_scanline_span_gen_top_defines.svh =====
// Assertion helpers for the span generator
`ifndef TRIANGLE_SCANLINE_SPAN_GEN_TOP_DEFINES_SVH
`define TRIANGLE_SCANLINE_SPAN_GEN_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define TSG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%s failed", "label");

// Next-cycle implication
`define TSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%s failed", "label");

`endif

// ===== rtl/tsg_pkg.sv =====
package tsg_pkg;

   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 16;
   // edge x and slope: sign + coordinate + fraction
   localparam int FX_BITS    = COORD_BITS + FRAC_BITS + 1;
   // dividend magnitude width
   localparam int NUM_BITS   = COORD_BITS + FRAC_BITS;
   localparam int QCNT_BITS  = $clog2(NUM_BITS + 1);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // datapath commands
   typedef struct packed {
      logic load;        // capture and sort vertices
      logic div_start;   // start a slope divide
      logic div_sel_b;   // 1: top-to-bottom edge, 0: edge A source
      logic div_mid;     // edge A source is middle-to-bottom
      logic step;        // emit span and advance
      logic switch_a;    // edge A restarts at middle vertex before step
   } tsg_cmd_type;

   // datapath status
   typedef struct packed {
      logic div_done;
      logic step_valid;  // triangle has a row to emit
      logic at_mid;      // current row is middle vertex row
   } tsg_sts_type;

endpackage

// ===== rtl/tsg_divider.sv =====
// Restoring divider, one quotient bit per cycle; signed result, zero for zero divisor.
module tsg_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [tsg_pkg::COORD_BITS:0] dx,
   input  logic signed [tsg_pkg::COORD_BITS:0] dy,
   output logic                                done,
   output logic signed [tsg_pkg::FX_BITS-1:0]  quot
);
   localparam int NB = tsg_pkg::NUM_BITS;
   localparam int CB = tsg_pkg::COORD_BITS;

   logic                            busy_ff, busy_in;
   logic [tsg_pkg::QCNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [NB-1:0]                   num_ff, num_in;
   logic [CB:0]                     rem_ff, rem_in;
   logic [CB-1:0]                   den_ff, den_in;
   logic                            neg_ff, neg_in;
   logic                            zero_ff, zero_in;
   logic                            done_ff, done_in;
   logic [CB:0]                     trial;
   logic [CB:0]                     mx, my;

   always_comb begin
      mx = dx[CB] ? (CB+1)'(-dx) : (CB+1)'(dx);
      my = dy[CB] ? (CB+1)'(-dy) : (CB+1)'(dy);
      trial = {rem_ff[CB-1:0], num_ff[NB-1]};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = tsg_pkg::QCNT_BITS'(NB);
         num_in = {mx[CB-1:0], {tsg_pkg::FRAC_BITS{1'b0}}};
         rem_in = '0;
         den_in = my[CB-1:0];
         neg_in = dx[CB] ^ dy[CB];
         zero_in = (dy == '0);
      end else if (busy_ff) begin
         num_in = {num_ff[NB-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == tsg_pkg::QCNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   assign done = done_ff;
   always_comb begin
      if (zero_ff) quot = '0;
      else if (neg_ff) quot = -$signed({1'b0, num_ff});
      else quot = $signed({1'b0, num_ff});
   end
endmodule

// ===== rtl/tsg_datapath.sv =====
// Vertex sort, edge registers, slope divider and span formatting.
module tsg_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  tsg_pkg::tsg_cmd_type              cmd,
   output tsg_pkg::tsg_sts_type              sts,
   input  logic [tsg_pkg::COORD_BITS-1:0]    ax, ay, bx, by_coord, cx, cy,
   output logic                              span_valid,
   output logic [tsg_pkg::COORD_BITS-1:0]    span_left,
   output logic [tsg_pkg::COORD_BITS-1:0]    span_right,
   output logic [tsg_pkg::COORD_BITS-1:0]    span_row,
   output logic                              last_span
);
   localparam int CB = tsg_pkg::COORD_BITS;
   localparam int FB = tsg_pkg::FRAC_BITS;
   localparam int FX = tsg_pkg::FX_BITS;

   logic [CB-1:0] vx_ff [3];
   logic [CB-1:0] vy_ff [3];
   logic [CB-1:0] vx_in [3];
   logic [CB-1:0] vy_in [3];
   logic signed [FX-1:0] ax_ff, ax_in, bx_ff, bx_in, as_ff, as_in, bs_ff, bs_in;
   logic [CB-1:0] row_ff, row_in;
   logic          active_ff, active_in;
   logic signed [CB:0] ddx, ddy;
   logic          div_done;
   logic signed [FX-1:0] quot;
   logic          div_b_ff, div_b_in;
   logic signed [FX-1:0] cur_a;
   logic [CB-1:0] xa, xb;
   logic [CB-1:0] row_nx;

   // stable three-element sort network
   always_comb begin
      logic [CB-1:0] tx, ty;
      tx = '0; ty = '0;
      vx_in[0] = ax; vy_in[0] = ay;
      vx_in[1] = bx; vy_in[1] = by_coord;
      vx_in[2] = cx; vy_in[2] = cy;
      if (vy_in[0] > vy_in[1]) begin
         tx = vx_in[0]; ty = vy_in[0];
         vx_in[0] = vx_in[1]; vy_in[0] = vy_in[1];
         vx_in[1] = tx; vy_in[1] = ty;
      end
      if (vy_in[1] > vy_in[2]) begin
         tx = vx_in[1]; ty = vy_in[1];
         vx_in[1] = vx_in[2]; vy_in[1] = vy_in[2];
         vx_in[2] = tx; vy_in[2] = ty;
      end
      if (vy_in[0] > vy_in[1]) begin
         tx = vx_in[0]; ty = vy_in[0];
         vx_in[0] = vx_in[1]; vy_in[0] = vy_in[1];
         vx_in[1] = tx; vy_in[1] = ty;
      end
   end

   // divider operand select
   always_comb begin
      if (cmd.div_sel_b) begin
         ddx = $signed({1'b0, vx_ff[0]}) - $signed({1'b0, vx_ff[2]});
         ddy = $signed({1'b0, vy_ff[0]}) - $signed({1'b0, vy_ff[2]});
      end else if (cmd.div_mid) begin
         ddx = $signed({1'b0, vx_ff[1]}) - $signed({1'b0, vx_ff[2]});
         ddy = $signed({1'b0, vy_ff[1]}) - $signed({1'b0, vy_ff[2]});
      end else begin
         ddx = $signed({1'b0, vx_ff[0]}) - $signed({1'b0, vx_ff[1]});
         ddy = $signed({1'b0, vy_ff[0]}) - $signed({1'b0, vy_ff[1]});
      end
   end

   tsg_divider u_div (
      .clock (clock), .reset (reset), .start (cmd.div_start),
      .dx (ddx), .dy (ddy), .done (div_done), .quot (quot)
   );

   function automatic logic [CB-1:0] pix(input logic signed [FX-1:0] f);
      if (f < 0) pix = '0;
      else pix = f[FX-2:FB];
   endfunction

   always_comb begin
      cur_a = cmd.switch_a ? $signed({1'b0, vx_ff[1], {FB{1'b0}}}) : ax_ff;
      xa = pix(cur_a);
      xb = pix(bx_ff);
      row_nx = row_ff + 1'b1;
   end

   // state update
   always_comb begin
      ax_in = ax_ff; bx_in = bx_ff; as_in = as_ff; bs_in = bs_ff;
      row_in = row_ff; active_in = active_ff; div_b_in = div_b_ff;
      if (cmd.div_start) div_b_in = cmd.div_sel_b;
      if (div_done) begin
         if (div_b_ff) bs_in = quot;
         else as_in = quot;
      end
      if (cmd.load) begin
         ax_in = $signed({1'b0, vx_in[0], {FB{1'b0}}});
         bx_in = ax_in;
         row_in = vy_in[0];
         active_in = vy_in[0] < vy_in[2];
      end else if (cmd.step) begin
         if (sts.step_valid) begin
            // on the middle row edge A advances by the freshly divided slope
            ax_in = cur_a + (cmd.switch_a ? quot : as_ff);
            bx_in = bx_ff + bs_ff;
            row_in = row_nx;
            if (row_nx >= vy_ff[2] || row_nx == '0) active_in = 1'b0;
         end else begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
         end
         ax_ff <= '0; bx_ff <= '0; as_ff <= '0; bs_ff <= '0;
         row_ff <= '0; active_ff <= 1'b0; div_b_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
               vx_ff[i] <= vx_in[i];
               vy_ff[i] <= vy_in[i];
            end
         end
         ax_ff <= ax_in; bx_ff <= bx_in; as_ff <= as_in; bs_ff <= bs_in;
         row_ff <= row_in; active_ff <= active_in; div_b_ff <= div_b_in;
      end
   end

   assign sts.div_done   = div_done;
   assign sts.step_valid = active_ff && (row_ff < vy_ff[2]);
   assign sts.at_mid     = (row_ff == vy_ff[1]);

   // span payload, combinational from current state
   assign span_valid = sts.step_valid;
   assign span_left  = sts.step_valid ? ((xa < xb) ? xa : xb) : '0;
   assign span_right = sts.step_valid ? ((xa < xb) ? xb : xa) : '0;
   assign span_row   = sts.step_valid ? row_ff : '0;
   assign last_span  = sts.step_valid && (row_nx == vy_ff[2]) && (row_ff != '1);
endmodule

// ===== rtl/tsg_ctrl.sv =====
// Controller: load sequences two slope divides; a step at the middle row divides first.
module tsg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_op,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  tsg_pkg::tsg_sts_type  sts,
   output tsg_pkg::tsg_cmd_type  cmd,
   output logic                  out_load
);
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIVA  = 6'b000010,
      ST_DIVB  = 6'b000100,
      ST_DIVM  = 6'b001000,
      ST_SPAN  = 6'b010000,
      ST_WAITB = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rvalid_ff, rvalid_in;
   logic      acc;

   assign req_tready = (state_ff == ST_IDLE) && !rvalid_ff;
   assign acc = req_tvalid && req_tready;
   assign rsp_tvalid = rvalid_ff;

   always_comb begin
      state_in = state_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      cmd = '0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req_op == tsg_pkg::OP_LOAD) begin
                  cmd.load = 1'b1;
                  state_in = ST_WAITB;
               end else if (sts.step_valid && sts.at_mid) begin
                  cmd.div_start = 1'b1;
                  cmd.div_mid = 1'b1;
                  state_in = ST_DIVM;
               end else begin
                  state_in = ST_SPAN;
               end
            end
         end
         ST_WAITB: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIVA;
         end
         ST_DIVA: if (sts.div_done) begin
            cmd.div_start = 1'b1;
            cmd.div_sel_b = 1'b1;
            state_in = ST_DIVB;
         end
         ST_DIVB: if (sts.div_done) state_in = ST_IDLE;
         ST_DIVM: if (sts.div_done) begin
            cmd.step = 1'b1;
            cmd.switch_a = 1'b1;
            out_load = 1'b1;
            rvalid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SPAN: begin
            cmd.step = 1'b1;
            out_load = 1'b1;
            rvalid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rvalid_ff <= rvalid_in;
      end
   end
endmodule

// ===== rtl/triangle_scanline_span_gen_top.sv =====
// A span response is registered: an accepted request moves the controller to its span
// state, which loads the response register and sets rsp_tvalid; on the middle-vertex
// row, edge A's slope is divided first. No request is taken while a span is in progress,
// and a response must drain before the next request is taken.
// A load keeps req_tready low through its two serial slope divides.
// Synchronous active-high reset clears vertices, edges, row and the active flag.
`include "triangle_scanline_span_gen_top_defines.svh"
module triangle_scanline_span_gen_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,       // operation
   input  logic [63:0] req_tdata,       // ax, ay, bx, by_coord, cx, cy (10 bits each)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,       // span_valid
   output logic        rsp_tlast,       // last_span
   output logic [31:0] rsp_tdata        // span_left, span_right, span_row (10 bits each)
);
   localparam int CB = tsg_pkg::COORD_BITS;

   tsg_pkg::tsg_cmd_type cmd;
   tsg_pkg::tsg_sts_type sts;
   logic out_load;
   logic sv;
   logic [CB-1:0] sl, sr, srow;
   logic slast;
   logic [31:0] data_ff;
   logic user_ff;
   logic last_ff;

   tsg_ctrl u_ctrl (
      .clock (clock), .reset (reset),
      .req_tvalid (req_tvalid), .req_tready (req_tready), .req_op (req_tuser),
      .rsp_tvalid (rsp_tvalid), .rsp_tready (rsp_tready),
      .sts (sts), .cmd (cmd), .out_load (out_load)
   );

   tsg_datapath u_dp (
      .clock (clock), .reset (reset), .cmd (cmd), .sts (sts),
      .ax (req_tdata[9:0]), .ay (req_tdata[19:10]), .bx (req_tdata[29:20]),
      .by_coord (req_tdata[39:30]), .cx (req_tdata[49:40]), .cy (req_tdata[59:50]),
      .span_valid (sv), .span_left (sl), .span_right (sr), .span_row (srow),
      .last_span (slast)
   );

   // response register
   always_ff @(posedge clock) begin
      if (out_load) begin
         data_ff <= {2'b0, srow, sr, sl};
         user_ff <= sv;
         last_ff <= slast;
      end
   end

   assign rsp_tdata = data_ff;
   assign rsp_tuser = user_ff;
   assign rsp_tlast = last_ff;

   `TSG_ASSERT_IMPL(a_no_accept_busy, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `TSG_ASSERT_IMPL(a_last_needs_valid, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser)
   `TSG_ASSERT_NEXT(a_load_no_rsp, clock, reset,
      req_tvalid && req_tready && !req_tuser, !rsp_tvalid)
endmodule
